// ----- design/tpbt_pkg.sv -----
// Shared types, widths, codes and reset values for the thread priority boost table.
package tpbt_pkg;

  localparam int IDX_W      = 6;
  localparam int PRIO_W     = 16;
  localparam int TIME_W     = 48;
  localparam int OP_W       = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_SEL_LSB = 3;

  localparam int DEF_THREAD_COUNT = 64;
  localparam int DEF_TIME_BITS    = 48;

  localparam logic signed [PRIO_W-1:0] RST_BEST     = 16'sd0;
  localparam logic signed [PRIO_W-1:0] RST_WORST    = 16'sd255;
  localparam logic signed [PRIO_W-1:0] RST_BASE     = 16'sd128;
  localparam logic signed [PRIO_W-1:0] RST_BOOST    = 16'sd0;
  localparam logic [TIME_W-1:0]        RST_QUANTUM  = 48'd1000000;

  typedef enum logic [OP_W-1:0] {
    OP_INIT      = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_SEND      = 3'd2,
    OP_RECV_MISS = 3'd3,
    OP_RECV_HIT  = 3'd4,
    OP_QUERY     = 3'd5,
    OP_EXECUTE   = 3'd6,
    OP_COPY      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    REG_BEST     = 3'd0,
    REG_WORST    = 3'd1,
    REG_BASE     = 3'd2,
    REG_BOOST_RF = 3'd3,
    REG_BOOST_RL = 3'd4,
    REG_BOOST_SL = 3'd5,
    REG_QUANTUM  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] best;
    logic signed [PRIO_W-1:0] worst;
    logic signed [PRIO_W-1:0] base;
    logic signed [PRIO_W-1:0] boost_rf;
    logic signed [PRIO_W-1:0] boost_rl;
    logic signed [PRIO_W-1:0] boost_sl;
    logic [TIME_W-1:0]        quantum;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EVAL   = 2'd1,
    ST_FINISH = 2'd2
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic finish;
  } dp_cmd_t;

endpackage

// ----- design/tpbt_if.sv -----
// Valid/ready channel interfaces for the request and result beats.
interface tpbt_in_if;
  logic                                valid;
  logic                                ready;
  logic [tpbt_pkg::OP_W-1:0]           operation;
  logic [tpbt_pkg::IDX_W-1:0]          thread_index;
  logic [tpbt_pkg::IDX_W-1:0]          source_thread;
  logic signed [tpbt_pkg::PRIO_W-1:0]  initial_priority;
  logic                                lost_cpu;
  logic [tpbt_pkg::TIME_W-1:0]         work_remaining;

  modport source (output valid, operation, thread_index, source_thread, initial_priority,
                  lost_cpu, work_remaining, input ready);
  modport sink (input valid, operation, thread_index, source_thread, initial_priority,
                lost_cpu, work_remaining, output ready);
endinterface

interface tpbt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tpbt_pkg::PRIO_W-1:0]  priority_now;
  logic                                priority_changed;
  logic [tpbt_pkg::TIME_W-1:0]         slice_time;
  logic [tpbt_pkg::TIME_W-1:0]         work_left;
  logic                                work_done;

  modport source (output valid, priority_now, priority_changed, slice_time, work_left,
                  work_done, input ready);
  modport sink (input valid, priority_now, priority_changed, slice_time, work_left,
                work_done, output ready);
endinterface

// ----- design/tpbt_regs.sv -----
// Configuration register file behind the APB-style port.
module tpbt_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tpbt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tpbt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tpbt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output tpbt_pkg::cfg_regs_t              cfg
);
  import tpbt_pkg::*;

  cfg_regs_t cfg_r;
  reg_idx_t  sel;
  logic      wr;

  assign sel    = reg_idx_t'(paddr[CFG_ADDR_W-1:REG_SEL_LSB]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.best     <= RST_BEST;
      cfg_r.worst    <= RST_WORST;
      cfg_r.base     <= RST_BASE;
      cfg_r.boost_rf <= RST_BOOST;
      cfg_r.boost_rl <= RST_BOOST;
      cfg_r.boost_sl <= RST_BOOST;
      cfg_r.quantum  <= RST_QUANTUM;
    end else if (wr) begin
      case (sel)
        REG_BEST:     cfg_r.best     <= signed'(pwdata[PRIO_W-1:0]);
        REG_WORST:    cfg_r.worst    <= signed'(pwdata[PRIO_W-1:0]);
        REG_BASE:     cfg_r.base     <= signed'(pwdata[PRIO_W-1:0]);
        REG_BOOST_RF: cfg_r.boost_rf <= signed'(pwdata[PRIO_W-1:0]);
        REG_BOOST_RL: cfg_r.boost_rl <= signed'(pwdata[PRIO_W-1:0]);
        REG_BOOST_SL: cfg_r.boost_sl <= signed'(pwdata[PRIO_W-1:0]);
        REG_QUANTUM:  cfg_r.quantum  <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Signed registers read back sign-extended.
  always_comb begin
    case (sel)
      REG_BEST:     prdata = CFG_DATA_W'(cfg_r.best);
      REG_WORST:    prdata = CFG_DATA_W'(cfg_r.worst);
      REG_BASE:     prdata = CFG_DATA_W'(cfg_r.base);
      REG_BOOST_RF: prdata = CFG_DATA_W'(cfg_r.boost_rf);
      REG_BOOST_RL: prdata = CFG_DATA_W'(cfg_r.boost_rl);
      REG_BOOST_SL: prdata = CFG_DATA_W'(cfg_r.boost_sl);
      REG_QUANTUM:  prdata = CFG_DATA_W'(cfg_r.quantum);
      default:      prdata = '0;
    endcase
  end

endmodule

// ----- design/tpbt_ctrl.sv -----
// Controller state machine that sequences one table operation at a time.
module tpbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tpbt_pkg::dp_cmd_t cmd
);
  import tpbt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/tpbt_dp.sv -----
// Datapath: entry tables, boost and clamp, quantum arithmetic and the result register.
module tpbt_dp #(
  parameter int THREAD_COUNT = tpbt_pkg::DEF_THREAD_COUNT,
  parameter int TIME_BITS    = tpbt_pkg::DEF_TIME_BITS
) (
  input  logic                               clk,
  input  tpbt_pkg::dp_cmd_t                  cmd,
  input  tpbt_pkg::cfg_regs_t                cfg,
  input  logic [tpbt_pkg::OP_W-1:0]          operation,
  input  logic [tpbt_pkg::IDX_W-1:0]         thread_index,
  input  logic [tpbt_pkg::IDX_W-1:0]         source_thread,
  input  logic signed [tpbt_pkg::PRIO_W-1:0] initial_priority,
  input  logic                               lost_cpu,
  input  logic [tpbt_pkg::TIME_W-1:0]        work_remaining,
  output logic signed [tpbt_pkg::PRIO_W-1:0] priority_now,
  output logic                               priority_changed,
  output logic [tpbt_pkg::TIME_W-1:0]        slice_time,
  output logic [tpbt_pkg::TIME_W-1:0]        work_left,
  output logic                               work_done
);
  import tpbt_pkg::*;

  localparam int AW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;
  localparam int TW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

  // Entry tables.
  logic signed [PRIO_W-1:0] prio_mem [THREAD_COUNT];
  logic [TW-1:0]            used_mem [THREAD_COUNT];

  // Request capture.
  op_t                      op_r;
  logic [AW-1:0]            waddr_r;
  logic                     idx_ok_r, src_ok_r, same_r, lost_r;
  logic signed [PRIO_W-1:0] init_prio_r;
  logic [TW-1:0]            work_r;
  logic signed [PRIO_W-1:0] prio_a_r, prio_b_r;
  logic [TW-1:0]            used_a_r, used_b_r;

  logic [XW-1:0] idx_x, src_x;
  logic [AW-1:0] addr_a, addr_b;

  assign idx_x  = XW'(thread_index);
  assign src_x  = XW'(source_thread);
  assign addr_a = idx_x[AW-1:0];
  assign addr_b = src_x[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= op_t'(operation);
      waddr_r     <= addr_a;
      idx_ok_r    <= int'(thread_index) < THREAD_COUNT;
      src_ok_r    <= int'(source_thread) < THREAD_COUNT;
      same_r      <= thread_index == source_thread;
      lost_r      <= lost_cpu;
      init_prio_r <= initial_priority;
      work_r      <= work_remaining[TW-1:0];
      prio_a_r    <= prio_mem[addr_a];
      used_a_r    <= used_mem[addr_a];
      prio_b_r    <= prio_mem[addr_b];
      used_b_r    <= used_mem[addr_b];
    end
  end

  // Entries outside the table read as zero.
  logic signed [PRIO_W-1:0] prio_a;
  logic [TW-1:0]            used_a, q;
  logic signed [PRIO_W-1:0] delta;

  assign prio_a = idx_ok_r ? prio_a_r : '0;
  assign used_a = idx_ok_r ? used_a_r : '0;
  assign q      = cfg.quantum[TW-1:0];

  always_comb begin
    case (op_r)
      OP_SEND:      delta = cfg.boost_sl;
      OP_RECV_MISS: delta = cfg.boost_rf;
      OP_RECV_HIT:  delta = cfg.boost_rl;
      default:      delta = '0;
    endcase
  end

  // First compute stage.
  logic signed [PRIO_W:0]   sum_r;
  logic signed [PRIO_W-1:0] old_prio_r, copy_prio_r;
  logic [TW-1:0]            old_used_r, copy_used_r, rest_r;
  logic                     restart_r;
  logic                     restart;

  assign restart = lost_r || (used_a >= q);

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      sum_r      <= signed'({prio_a[PRIO_W-1], prio_a}) + signed'({delta[PRIO_W-1], delta});
      old_prio_r <= prio_a;
      old_used_r <= used_a;
      restart_r  <= restart;
      rest_r     <= restart ? q : q - used_a;
      if (same_r) begin
        copy_prio_r <= prio_a;
        copy_used_r <= used_a;
      end else begin
        copy_prio_r <= src_ok_r ? prio_b_r : '0;
        copy_used_r <= src_ok_r ? used_b_r : '0;
      end
    end
  end

  // Second compute stage: clamp, slice and write-back.
  logic signed [PRIO_W:0]   best_x, worst_x, lo_clamp, hi_clamp;
  logic [TW:0]              diff;
  logic                     short_work;
  logic [TW-1:0]            slice, left, used_sum, used_new;

  assign best_x   = signed'({cfg.best[PRIO_W-1], cfg.best});
  assign worst_x  = signed'({cfg.worst[PRIO_W-1], cfg.worst});
  assign lo_clamp = (sum_r < best_x) ? best_x : sum_r;
  assign hi_clamp = (lo_clamp > worst_x) ? worst_x : lo_clamp;

  // The borrow of work minus rest tells which bound sets the slice.
  assign diff       = {1'b0, work_r} - {1'b0, rest_r};
  assign short_work = diff[TW];
  assign slice      = short_work ? work_r : rest_r;
  assign left       = short_work ? '0 : diff[TW-1:0];
  assign used_sum   = old_used_r + work_r;
  assign used_new   = restart_r ? slice : (short_work ? used_sum : q);

  logic signed [PRIO_W-1:0] res_prio, wr_prio;
  logic                     res_changed, res_done, do_write;
  logic [TW-1:0]            res_slice, res_left, wr_used;

  always_comb begin
    res_prio    = old_prio_r;
    res_changed = 1'b0;
    res_slice   = '0;
    res_left    = '0;
    res_done    = 1'b0;
    do_write    = 1'b0;
    wr_prio     = old_prio_r;
    wr_used     = old_used_r;
    case (op_r)
      OP_INIT: begin
        res_prio = init_prio_r;
        wr_prio  = init_prio_r;
        wr_used  = '0;
        do_write = 1'b1;
      end
      OP_CLEAR: begin
        res_prio = cfg.base;
        wr_prio  = cfg.base;
        wr_used  = '0;
        do_write = 1'b1;
      end
      OP_SEND, OP_RECV_MISS, OP_RECV_HIT: begin
        res_prio    = hi_clamp[PRIO_W-1:0];
        res_changed = hi_clamp != signed'({old_prio_r[PRIO_W-1], old_prio_r});
        wr_prio     = hi_clamp[PRIO_W-1:0];
        do_write    = 1'b1;
      end
      OP_EXECUTE: begin
        res_slice = slice;
        res_left  = left;
        res_done  = left == '0;
        wr_used   = used_new;
        do_write  = 1'b1;
      end
      OP_COPY: begin
        res_prio = idx_ok_r ? copy_prio_r : '0;
        wr_prio  = copy_prio_r;
        wr_used  = copy_used_r;
        do_write = !same_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && do_write && idx_ok_r) begin
      prio_mem[waddr_r] <= wr_prio;
      used_mem[waddr_r] <= wr_used;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      priority_now     <= res_prio;
      priority_changed <= res_changed;
      slice_time       <= TIME_W'(res_slice);
      work_left        <= TIME_W'(res_left);
      work_done        <= res_done;
    end
  end

endmodule

// ----- design/thread_priority_boost_table_unit.sv -----
// Top level of the thread priority boost table.
//
// This block keeps a priority and a used-quantum count for each of THREAD_COUNT
// threads and applies one scheduling operation per request beat: init, clear,
// the three message boosts with clamping to the best..worst range, query,
// execute (time slice grant against the quantum) and copy. Every request beat
// yields exactly one result beat. An operation passes from acceptance to the
// result register through the accept, eval and finish steps: accept reads the
// entry tables, eval forms the boosted sum and the rest of the quantum, and
// finish clamps, finishes the slice arithmetic, writes the entry back and
// loads the result. A new request is taken in the cycle after the finish
// step, so the read-modify-write of one table entry completes before the
// next request reads the tables. A finished result waits in its own
// register, and the next request is accepted while it waits; only the
// finish step (write-back and result load) stalls when the result register
// is still full. Configuration registers sit on an APB-style port at byte
// address 8*i with 64-bit data; the user must write them only while no
// request is in flight; the block does not enforce it. Table entries have
// no reset and must be written by init, clear or copy before they are read.
module thread_priority_boost_table_unit #(
  parameter int THREAD_COUNT = tpbt_pkg::DEF_THREAD_COUNT,
  parameter int TIME_BITS    = tpbt_pkg::DEF_TIME_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tpbt_in_if.sink                          in_ch,
  tpbt_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tpbt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tpbt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tpbt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import tpbt_pkg::*;

  cfg_regs_t cfg;
  dp_cmd_t   cmd;

  // Configuration registers.
  tpbt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: owns the request handshake and the result valid flag.
  tpbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Tables and arithmetic; the result payload register lives here.
  tpbt_dp #(
    .THREAD_COUNT (THREAD_COUNT),
    .TIME_BITS    (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .cfg              (cfg),
    .operation        (in_ch.operation),
    .thread_index     (in_ch.thread_index),
    .source_thread    (in_ch.source_thread),
    .initial_priority (in_ch.initial_priority),
    .lost_cpu         (in_ch.lost_cpu),
    .work_remaining   (in_ch.work_remaining),
    .priority_now     (out_ch.priority_now),
    .priority_changed (out_ch.priority_changed),
    .slice_time       (out_ch.slice_time),
    .work_left        (out_ch.work_left),
    .work_done        (out_ch.work_done)
  );

endmodule

// ----- design/tpbt_chk.sv -----
// Port-level checker for the thread priority boost table, bound to the top level.
module tpbt_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [tpbt_pkg::PRIO_W-1:0] out_priority_now,
  input logic                             out_priority_changed,
  input logic [tpbt_pkg::TIME_W-1:0]      out_slice_time,
  input logic [tpbt_pkg::TIME_W-1:0]      out_work_left,
  input logic                             out_work_done
);
  import tpbt_pkg::*;

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_priority_now) &&
      $stable(out_slice_time) && $stable(out_work_left) && $stable(out_work_done))
    else $error("stalled result beat changed");

  // A fresh result is only produced while the request side is busy.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a request in flight");

  // Finished work leaves nothing over, and only execute reports it.
  a_done_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_work_done |-> out_work_left == '0 && !out_priority_changed)
    else $error("work_done inconsistent with work_left or boost flag");

  // A boost never grants a time slice.
  a_boost_no_slice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_priority_changed |-> out_slice_time == '0)
    else $error("boost result carries a time slice");

endmodule

bind thread_priority_boost_table_unit tpbt_chk u_tpbt_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_priority_now     (out_ch.priority_now),
  .out_priority_changed (out_ch.priority_changed),
  .out_slice_time       (out_ch.slice_time),
  .out_work_left        (out_ch.work_left),
  .out_work_done        (out_ch.work_done)
);
